@@ rtl/lkc_pkg.sv @@
`default_nettype none

package lkc_pkg;

  // Default sizing of the cell row.
  localparam int DEF_ENTRIES  = 8;
  localparam int DEF_KEY_BITS = 32;

  // Fixed field widths of the ports.
  localparam int KEY_PORT_BITS = 32;
  localparam int CAP_BITS      = 4;
  localparam int OCC_BITS      = 4;

  // Register port.
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 2;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd8;

  // Request modes.
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } lkc_state_t;

  // Per-cell control: load takes the neighbor's key (the new key for the
  // front cell), evict_sel puts the held key on the eviction bus.
  typedef struct packed {
    logic load;
    logic evict_sel;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/lru_key_cache_core.sv @@
`default_nettype none

// Recency-ordered key cache, most recent key first.
//
// Requests come in on the in channel (in_valid, in_stall, mode, key) and one
// result transaction per request leaves on the out channel (out_valid,
// out_stall, hit, evicted, evicted_key, occupancy). A lookup (mode 0) that
// finds its key moves the most recent copy to the front and reports a hit.
// An insert (mode 1) evicts the least recent key when the cache is full and
// places the new key at the front without a duplicate check.
//
// Each request has an accept cycle and an update cycle. In the accept cycle
// the key is compared against every cell of the row and the shift plan is
// registered; in the update cycle the row shifts and the result register
// loads. The row is updated only then, so no new request is taken before the
// previous one has updated. out_valid is registered at the update. If the
// result register still holds an untaken result, the update cycle waits and
// in_stall stays high. Reset empties the cache and sets capacity to 8; no
// clearing pass is needed. The capacity register sits at byte address 0 of
// the APB port.
module lru_key_cache_core #(
  parameter int ENTRIES  = lkc_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = lkc_pkg::DEF_KEY_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 mode,
  input  logic [lkc_pkg::KEY_PORT_BITS-1:0]    key,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 hit,
  output logic                                 evicted,
  output logic [lkc_pkg::KEY_PORT_BITS-1:0]    evicted_key,
  output logic [lkc_pkg::OCC_BITS-1:0]         occupancy,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lkc_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [lkc_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [lkc_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                 pready
);
  import lkc_pkg::*;

  // Only the low KW bits (KEY_BITS, at most 32) of the key take part; the port carries 32.
  localparam int KW = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;

  logic [KW-1:0]            req_key;
  logic [KW-1:0]            front_key;
  logic [KW-1:0]            evict_bus;
  logic [ENTRIES-1:0]       match_vec;
  cell_ctl_t [ENTRIES-1:0]  ctl;
  logic [KW-1:0]            cell_key   [ENTRIES];
  logic [KW-1:0]            cell_in    [ENTRIES];
  logic [KW-1:0]            cell_evict [ENTRIES];

  assign req_key = key[KW-1:0];

  lkc_ctrl #(
    .ENTRIES (ENTRIES),
    .KW      (KW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .req_key     (req_key),
    .match_vec   (match_vec),
    .evict_bus   (evict_bus),
    .front_key   (front_key),
    .ctl         (ctl),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .evicted     (evicted),
    .evicted_key (evicted_key),
    .occupancy   (occupancy),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // The row of cells: position 0 is the most recent key. On a shift each
  // cell takes the key of its more recent neighbor, and the front cell takes
  // the request key.
  for (genvar p = 0; p < ENTRIES; p++) begin : g_cell
    if (p == 0) begin : g_front
      assign cell_in[p] = front_key;
    end else begin : g_rest
      assign cell_in[p] = cell_key[p-1];
    end

    lkc_cell #(
      .KW (KW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl[p]),
      .cmp_key   (req_key),
      .shift_in  (cell_in[p]),
      .key_out   (cell_key[p]),
      .match     (match_vec[p]),
      .evict_key (cell_evict[p])
    );
  end

  // At most one cell drives the eviction bus, so an OR merges them.
  always_comb begin
    evict_bus = '0;
    for (int p = 0; p < ENTRIES; p++) begin
      evict_bus = evict_bus | cell_evict[p];
    end
  end

endmodule

`default_nettype wire

@@ rtl/lkc_cell.sv @@
`default_nettype none

module lkc_cell #(
  parameter int KW = 32
) (
  input  logic               clk,
  input  lkc_pkg::cell_ctl_t ctl,
  input  logic [KW-1:0]      cmp_key,
  input  logic [KW-1:0]      shift_in,
  output logic [KW-1:0]      key_out,
  output logic               match,
  output logic [KW-1:0]      evict_key
);
  import lkc_pkg::*;

  logic [KW-1:0] slot_key;

  // The cell holds the key of one recency position. A shift moves the key of
  // the more recent neighbor in.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      slot_key <= shift_in;
    end
  end

  assign key_out   = slot_key;
  assign match     = (slot_key == cmp_key);
  assign evict_key = slot_key & {KW{ctl.evict_sel}};

endmodule

`default_nettype wire

@@ rtl/lkc_ctrl.sv @@
`default_nettype none

module lkc_ctrl #(
  parameter int ENTRIES = 8,
  parameter int KW      = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // request side
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 mode,
  input  logic [KW-1:0]                        req_key,
  // cell row
  input  logic [ENTRIES-1:0]                   match_vec,
  input  logic [KW-1:0]                        evict_bus,
  output logic [KW-1:0]                        front_key,
  output lkc_pkg::cell_ctl_t [ENTRIES-1:0]     ctl,
  // result side
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 hit,
  output logic                                 evicted,
  output logic [lkc_pkg::KEY_PORT_BITS-1:0]    evicted_key,
  output logic [lkc_pkg::OCC_BITS-1:0]         occupancy,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lkc_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [lkc_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [lkc_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                 pready
);
  import lkc_pkg::*;

  localparam int FW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (FW > CAP_BITS) ? FW : CAP_BITS;

  lkc_state_t state, state_next;

  logic [CAP_BITS-1:0] capacity;
  logic [FW-1:0]       fill, fill_next, fill_keep;

  logic                mode_q, hit_q, evict_q;
  logic [KW-1:0]       key_q;
  logic [ENTRIES-1:0]  shift_q, sel_q;

  logic [ENTRIES-1:0]  live, hits, shift_d, sel_d;
  logic                hit_d, evict_d;
  logic                accept, update, cfg_write;

  // Only one register exists, so every word of the address space maps to it.
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = APB_DATA_BITS'(capacity);

  assign accept = in_valid && !in_stall;

  // Plan of the update, worked out while the key is compared.
  always_comb begin
    for (int p = 0; p < ENTRIES; p++) begin
      live[p] = (FW'(p) < fill);
    end
    hits    = match_vec & live;
    hit_d   = |hits;
    evict_d = (fill != '0) &&
              ((CMPW'(fill) >= CMPW'(capacity)) || (fill == FW'(ENTRIES)));
    fill_keep = fill - FW'(evict_d);
    for (int p = 0; p < ENTRIES; p++) begin
      if (mode == MODE_INSERT) begin
        shift_d[p] = (FW'(p) <= fill_keep);
      end else begin
        shift_d[p] = hit_d && !(|(hits & ~({ENTRIES{1'b1}} << p)));
      end
      sel_d[p] = evict_d && (mode == MODE_INSERT) && (FW'(p + 1) == fill);
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    update     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (accept) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        update = !out_valid || !out_stall;
        if (update) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    fill_next = fill;
    if (update && (mode_q == MODE_INSERT)) begin
      fill_next = fill - FW'(evict_q) + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      capacity  <= CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (cfg_write) begin
        capacity <= pwdata[CAP_BITS-1:0];
      end
      if (update) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q  <= mode;
      key_q   <= req_key;
      hit_q   <= hit_d && (mode == MODE_LOOKUP);
      evict_q <= evict_d && (mode == MODE_INSERT);
      shift_q <= shift_d;
      sel_q   <= sel_d;
    end
    if (update) begin
      hit         <= hit_q;
      evicted     <= evict_q;
      evicted_key <= KEY_PORT_BITS'(evict_bus);
      occupancy   <= OCC_BITS'(fill_next);
    end
  end

  assign front_key = key_q;

  always_comb begin
    for (int p = 0; p < ENTRIES; p++) begin
      ctl[p].load      = update && shift_q[p];
      ctl[p].evict_sel = sel_q[p];
    end
  end

endmodule

`default_nettype wire

@@ rtl/lkc_checker.sv @@
`default_nettype none

module lkc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        hit,
  input wire logic        evicted,
  input wire logic [31:0] evicted_key,
  input wire logic [3:0]  occupancy
);

  // A request keeps the block busy in the cycle after it is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while the previous one is still in flight");

  // A hit, which only a lookup reports, never comes with an eviction.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> !evicted)
    else $error("result reports both a hit and an eviction");

  // Without an eviction the evicted key reads zero.
  a_evict_key_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !evicted) |-> (evicted_key == 32'd0))
    else $error("evicted key is nonzero without an eviction");

  // A hit or an eviction implies a nonempty cache.
  a_occ_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (hit || evicted)) |-> (occupancy != 4'd0))
    else $error("hit or eviction reported with an empty cache");

  // A stalled result stays put.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(occupancy) && $stable(evicted_key)))
    else $error("stalled result changed");

endmodule

bind lru_key_cache_core lkc_checker u_lkc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .hit         (hit),
  .evicted     (evicted),
  .evicted_key (evicted_key),
  .occupancy   (occupancy)
);

`default_nettype wire
